### hw/rtl/cidm_pkg.sv
// Package with shared constants and types of the CAN ID frame monitor table.
package cidm_pkg;
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int ID_W = 29;
	localparam int DATA_W = 64;
	localparam int TIME_W = 32;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	localparam logic [1:0] ST_UPDATED = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	// One table entry; flags hold extended, bus and dlc as {dlc, bus, ext}.
	typedef struct packed {
		logic [ID_W-1:0]   key;
		logic [6:0]        flags;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] prev;
		logic [31:0]       hits;
		logic [TIME_W-1:0] first_t;
		logic [TIME_W-1:0] last_t;
	} entry_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SRCH   = 7'b0000010,
		S_SWAIT  = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_SHRD   = 7'b0010000,
		S_SHWR   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;
endpackage

### hw/rtl/can_id_frame_monitor_table.sv
// Top level of the CAN ID frame monitor table.
// A transaction is taken when start is high and busy is low; its one result appears
// for a single cycle with done high and cannot be held off. A frame does a binary
// search for a lookup or update, and on insert moves up every entry from its slot on,
// one read and one write each through the single port of the entry memory. No clearing
// pass is needed after reset.
module can_id_frame_monitor_table import cidm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [ID_W-1:0]   can_id,
	input  logic              extended,
	input  logic [1:0]        bus,
	input  logic [3:0]        dlc,
	input  logic [DATA_W-1:0] payload,
	input  logic [TIME_W-1:0] timestamp_ms,
	output logic              done,
	output logic [1:0]        status,
	output logic [7:0]        slot,
	output logic              payload_changed,
	output logic [31:0]       id_frames,
	output logic [DATA_W-1:0] previous_payload,
	output logic [31:0]       total_frames,
	output logic [8:0]        entries_used
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	state_t            state_q;
	logic [CW-1:0]     used_q, lo_q, hi_q, idx_q;
	logic [31:0]       total_q;
	logic              action_q, ext_q;
	logic [ID_W-1:0]   id_q;
	logic [1:0]        bus_q;
	logic [3:0]        dlc_q;
	logic [DATA_W-1:0] data_q;
	logic [TIME_W-1:0] time_q;

	logic          we;
	logic [AW-1:0] addr;
	entry_t        wdata, rdata;
	logic [CW-1:0] mid;

	cidm_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign busy = (state_q != S_IDLE);

	logic hit;
	assign hit = (lo_q < used_q) && (rdata.key == id_q);

	always_comb begin
		we = 1'b0;
		addr = mid[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_CHECK: begin
				addr = lo_q[AW-1:0];
				if (hit) begin
					we = 1'b1;
					if (rdata.data != data_q) begin
						wdata.prev = rdata.data;
					end
					wdata.data = data_q;
					wdata.flags = {dlc_q, bus_q, rdata.flags[0]};
					wdata.hits = (rdata.hits == SAT32) ? rdata.hits : rdata.hits + 32'd1;
					wdata.last_t = time_q;
				end else begin
					// Start the move from the top: read the entry below the first free slot.
					addr = AW'(used_q - CW'(1));
				end
			end
			S_SHRD: addr = AW'(idx_q - CW'(1));
			S_SHWR: begin
				we = 1'b1;
				addr = idx_q[AW-1:0];
				if (idx_q == lo_q) begin
					wdata.key = id_q;
					wdata.flags = {dlc_q, bus_q, ext_q};
					wdata.data = data_q;
					wdata.prev = '0;
					wdata.hits = 32'd1;
					wdata.first_t = time_q;
					wdata.last_t = time_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			total_q <= '0;
			done <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			idx_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					action_q <= action;
					id_q <= can_id;
					ext_q <= extended;
					bus_q <= bus;
					dlc_q <= dlc;
					data_q <= payload;
					time_q <= timestamp_ms;
					lo_q <= '0;
					hi_q <= used_q;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (action_q) begin
						used_q <= '0;
						total_q <= '0;
						status <= ST_CLEARED;
						slot <= '0;
						payload_changed <= 1'b0;
						id_frames <= '0;
						previous_payload <= '0;
						total_frames <= '0;
						entries_used <= '0;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (lo_q < hi_q) begin
						state_q <= S_SWAIT;
					end else begin
						total_q <= (total_q == SAT32) ? total_q : total_q + 32'd1;
						state_q <= S_CHECK;
					end
				end
				S_SWAIT: begin
					if (rdata.key < id_q) lo_q <= mid + CW'(1);
					else hi_q <= mid;
					state_q <= S_SRCH;
				end
				S_CHECK: begin
					total_frames <= total_q;
					if (hit) begin
						status <= ST_UPDATED;
						slot <= 8'(lo_q);
						payload_changed <= (rdata.data != data_q);
						id_frames <= wdata.hits;
						previous_payload <= wdata.prev;
						entries_used <= 9'(used_q);
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (used_q >= CW'(TABLE_DEPTH)) begin
						status <= ST_DROPPED;
						slot <= '0;
						payload_changed <= 1'b0;
						id_frames <= '0;
						previous_payload <= '0;
						entries_used <= 9'(used_q);
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						slot <= 8'(lo_q);
						idx_q <= used_q;
						// The entry below the first free slot is read in this cycle.
						state_q <= S_SHWR;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (idx_q == lo_q) begin
						used_q <= used_q + CW'(1);
						status <= ST_INSERTED;
						payload_changed <= 1'b1;
						id_frames <= 32'd1;
						previous_payload <= '0;
						entries_used <= 9'(used_q + CW'(1));
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q - CW'(1);
						state_q <= S_SHRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/cidm_ram.sv
// Single-port entry memory of the monitor table with registered read data.
module cidm_ram import cidm_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  entry_t        wdata,
	output entry_t        rdata
);
	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### hw/rtl/cidm_checker.sv
// Port-level checker of the CAN ID frame monitor table, bound to the top level.
module cidm_checker import cidm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic       payload_changed,
	input logic [31:0] id_frames,
	input logic [8:0] entries_used
);
	// A result only ends a transaction that was in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a transaction");
	// A transaction accepted cannot finish in the very next cycle's edge.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction not busy");
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_INSERTED) |-> (payload_changed && id_frames == 32'd1))
		else $error("insert result malformed");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_CLEARED) |-> (entries_used == 9'd0))
		else $error("clear left entries");
endmodule

bind can_id_frame_monitor_table cidm_checker u_cidm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .payload_changed(payload_changed), .id_frames(id_frames),
	.entries_used(entries_used)
);

### tb/sv/can_id_frame_monitor_table_tb.sv
// Self-checking testbench of the CAN ID frame monitor table.
`timescale 1ns / 100ps

module can_id_frame_monitor_table_tb;
	import cidm_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int MAX_CYCLES = 3000000;

	typedef struct {
		logic [1:0]        status;
		logic [7:0]        slot;
		logic              payload_changed;
		logic [31:0]       id_frames;
		logic [DATA_W-1:0] previous_payload;
		logic [31:0]       total_frames;
		logic [8:0]        entries_used;
	} outcome_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              action;
	logic [ID_W-1:0]   can_id;
	logic              extended;
	logic [1:0]        bus;
	logic [3:0]        dlc;
	logic [DATA_W-1:0] payload;
	logic [TIME_W-1:0] timestamp_ms;
	logic              done;
	logic [1:0]        status;
	logic [7:0]        slot;
	logic              payload_changed;
	logic [31:0]       id_frames;
	logic [DATA_W-1:0] previous_payload;
	logic [31:0]       total_frames;
	logic [8:0]        entries_used;

	can_id_frame_monitor_table uut (.*);

	// Shadow copy of the ID table.
	logic [ID_W-1:0]   tbl_id[DEPTH];
	logic [DATA_W-1:0] tbl_data[DEPTH];
	logic [DATA_W-1:0] tbl_prev[DEPTH];
	logic [31:0]       tbl_hits[DEPTH];
	int unsigned       tbl_used;
	logic [31:0]       frame_count;

	outcome_t    pending_outcomes[$];
	int unsigned errors;
	int unsigned sent_frames;
	int unsigned sent_clears;
	int unsigned inserts_seen;
	int unsigned drops_seen;
	longint      cycle_count;
	logic [ID_W-1:0] id_pool[$];

	function automatic outcome_t predict_monitor(logic act, logic [ID_W-1:0] id,
			logic [DATA_W-1:0] data);
		outcome_t    o;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		o = '{default: '0};
		if (act) begin
			tbl_used = 0;
			frame_count = 0;
			o.status = ST_CLEARED;
			return o;
		end
		if (frame_count != SAT32)
			frame_count++;
		lo = 0;
		hi = tbl_used;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_id[mid] < id)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo < tbl_used && tbl_id[lo] == id) begin
			o.payload_changed = (tbl_data[lo] != data);
			if (o.payload_changed)
				tbl_prev[lo] = tbl_data[lo];
			tbl_data[lo] = data;
			if (tbl_hits[lo] != SAT32)
				tbl_hits[lo]++;
			o.status = ST_UPDATED;
			o.slot = lo[7:0];
			o.id_frames = tbl_hits[lo];
			o.previous_payload = tbl_prev[lo];
		end else if (tbl_used >= DEPTH) begin
			o.status = ST_DROPPED;
		end else begin
			for (int i = tbl_used; i > lo; i--) begin
				tbl_id[i] = tbl_id[i-1];
				tbl_data[i] = tbl_data[i-1];
				tbl_prev[i] = tbl_prev[i-1];
				tbl_hits[i] = tbl_hits[i-1];
			end
			tbl_id[lo] = id;
			tbl_data[lo] = data;
			tbl_prev[lo] = '0;
			tbl_hits[lo] = 1;
			tbl_used++;
			o.status = ST_INSERTED;
			o.slot = lo[7:0];
			o.payload_changed = 1'b1;
			o.id_frames = 1;
		end
		o.total_frames = frame_count;
		o.entries_used = tbl_used[8:0];
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > MAX_CYCLES) begin
				$display("can_id_frame_monitor_table verification failed");
				$finish;
			end
		end
	end

	// Compares every result against the oldest expected outcome.
	initial begin
		outcome_t exp_o;
		forever begin
			@(posedge clk);
			if (arst_n && done) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no transaction outstanding");
					errors++;
				end else begin
					exp_o = pending_outcomes.pop_front();
					if (status != exp_o.status) begin
						$error("status exp %0d got %0d", exp_o.status, status);
						errors++;
					end
					if (slot != exp_o.slot) begin
						$error("slot exp %0d got %0d", exp_o.slot, slot);
						errors++;
					end
					if (payload_changed != exp_o.payload_changed) begin
						$error("payload_changed exp %0d got %0d", exp_o.payload_changed,
							payload_changed);
						errors++;
					end
					if (id_frames != exp_o.id_frames) begin
						$error("id_frames exp %0d got %0d", exp_o.id_frames, id_frames);
						errors++;
					end
					if (previous_payload != exp_o.previous_payload) begin
						$error("previous_payload exp %h got %h", exp_o.previous_payload,
							previous_payload);
						errors++;
					end
					if (total_frames != exp_o.total_frames) begin
						$error("total_frames exp %0d got %0d", exp_o.total_frames,
							total_frames);
						errors++;
					end
					if (entries_used != exp_o.entries_used) begin
						$error("entries_used exp %0d got %0d", exp_o.entries_used,
							entries_used);
						errors++;
					end
					if (exp_o.status == ST_INSERTED)
						inserts_seen++;
					if (exp_o.status == ST_DROPPED)
						drops_seen++;
				end
			end
		end
	end

	// Start stays high between back-to-back transactions; busy keeps the block
	// from taking the old values again, and drain lowers it.
	task automatic send_transaction(logic act, logic [ID_W-1:0] id, logic ext,
			logic [1:0] b, logic [3:0] len, logic [DATA_W-1:0] data,
			logic [TIME_W-1:0] ts, bit allow_gap = 1'b1);
		int gap;
		gap = allow_gap ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		can_id <= id;
		extended <= ext;
		bus <= b;
		dlc <= len;
		payload <= data;
		timestamp_ms <= ts;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_outcomes.push_back(predict_monitor(act, id, data));
		if (act)
			sent_clears++;
		else
			sent_frames++;
	endtask

	task automatic send_frame(logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
		send_transaction(1'b0, id, 1'($urandom), 2'($urandom), 4'($urandom), data,
			$urandom);
	endtask

	task automatic send_clear();
		send_transaction(1'b1, ID_W'($urandom), 1'($urandom), 2'($urandom),
			4'($urandom), {$urandom, $urandom}, $urandom);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic test_field_extremes();
		send_transaction(1'b0, '1, 1'b1, 2'd3, 4'hF, '1, '1);
		send_transaction(1'b0, '0, 1'b0, 2'd0, 4'h0, '0, '0);
		send_transaction(1'b0, 29'h7FF, 1'b0, 2'd1, 4'd8, 64'h0123_4567_89AB_CDEF, 32'd5);
		send_transaction(1'b0, '0, 1'b1, 2'd2, 4'd9, '0, 32'd6);
		send_transaction(1'b0, '0, 1'b0, 2'd1, 4'd3, 64'h55, 32'd7);
		send_transaction(1'b0, '1, 1'b0, 2'd0, 4'd1, '0, 32'd8);
		send_transaction(1'b0, 29'h7FF, 1'b1, 2'd3, 4'd8, 64'h0123_4567_89AB_CDEF, 32'd9);
		send_transaction(1'b0, 29'h400, 1'b0, 2'd0, 4'd2, 64'hAAAA, 32'd10);
		send_clear();
		send_transaction(1'b0, 29'h400, 1'b0, 2'd0, 4'd2, 64'hAAAA, 32'd11);
		// Pause until the table has caught up before the next phase.
		drain();
	endtask

	task automatic test_fill_and_drop();
		logic [ID_W-1:0] id;
		send_clear();
		// Every third ID is a descending small ID, so its insert lands low and shifts the entries above it.
		for (int i = 0; i < DEPTH; i++) begin
			id = (i % 3 == 0) ? ID_W'(DEPTH * 4 - i * 4) : ID_W'($urandom);
			send_frame(id, {$urandom, $urandom});
		end
		for (int i = 0; i < 12; i++)
			send_frame(ID_W'($urandom), {$urandom, $urandom});
		for (int i = 0; i < 8; i++)
			send_frame(tbl_id[$urandom_range(0, tbl_used - 1)], {$urandom, $urandom});
		drain();
	endtask

	task automatic test_random_traffic();
		logic [ID_W-1:0] id;
		logic [DATA_W-1:0] data;
		int              pick;
		send_clear();
		id_pool.delete();
		for (int i = 0; i < 24; i++)
			id_pool.push_back(($urandom_range(0, 1)) ? ID_W'($urandom_range(0, 2047))
				: ID_W'($urandom));
		for (int n = 0; n < 360; n++) begin
			pick = $urandom_range(0, 99);
			id = id_pool[$urandom_range(0, id_pool.size() - 1)];
			if (pick < 2) begin
				send_clear();
			end else if (pick < 20) begin
				send_frame(ID_W'($urandom), {$urandom, $urandom});
			end else begin
				// Repeats often carry the same data so unchanged payloads occur.
				data = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
					: 64'(id) * 64'h9E37_79B9;
				send_frame(id, data);
			end
			if (n % 120 == 119)
				drain();
		end
		drain();
	endtask

	initial begin
		errors = 0;
		sent_frames = 0;
		sent_clears = 0;
		inserts_seen = 0;
		drops_seen = 0;
		tbl_used = 0;
		frame_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		can_id = '0;
		extended = 1'b0;
		bus = '0;
		dlc = '0;
		payload = '0;
		timestamp_ms = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_field_extremes();
		test_fill_and_drop();
		test_random_traffic();

		repeat (600) @(negedge clk);
		$display("Covered %0d frames and %0d clears: %0d inserts, %0d drops on a full table.",
			sent_frames, sent_clears, inserts_seen, drops_seen);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("can_id_frame_monitor_table verification clean");
		else
			$display("can_id_frame_monitor_table verification failed");
		$finish;
	end
endmodule

### can_id_frame_monitor_table.f
hw/rtl/cidm_pkg.sv
hw/rtl/cidm_ram.sv
hw/rtl/can_id_frame_monitor_table.sv
hw/rtl/cidm_checker.sv
tb/sv/can_id_frame_monitor_table_tb.sv
